// ===== rtl/core/mbb_pkg.sv =====
package mbb_pkg;

  localparam int BiasW = 13;

  typedef logic signed [BiasW-1:0] bias_t;

  typedef enum logic [2:0] {
    OP_REGISTER   = 3'd0,
    OP_UNREGISTER = 3'd1,
    OP_SET_TARGET = 3'd2,
    OP_LOCK       = 3'd3,
    OP_STREAM     = 3'd4,
    OP_FORCE_ALL  = 3'd5,
    OP_TICK       = 3'd6,
    OP_QUERY      = 3'd7
  } op_e;

  localparam logic [1:0] STRAT_PRESSURE = 2'd2;

  localparam logic [2:0] CFG_MIN_BIAS       = 3'd0;
  localparam logic [2:0] CFG_MAX_BIAS       = 3'd1;
  localparam logic [2:0] CFG_GLOBAL_OFFSET  = 3'd2;
  localparam logic [2:0] CFG_BLEND_RATE     = 3'd3;
  localparam logic [2:0] CFG_STREAMING_BIAS = 3'd4;
  localparam logic [2:0] CFG_PRESSURE_START = 3'd5;
  localparam logic [2:0] CFG_PRESSURE_FULL  = 3'd6;

  localparam int InDataW  = 56;
  localparam int OutDataW = 16;

  // one decoded request as it waits between the front and back parts
  typedef struct packed {
    op_e         op;
    logic        bulk;
    logic [5:0]  material;
    logic [1:0]  strategy;
    bias_t       bias_value;
    logic        flag;
    logic [15:0] delta_time;
    logic [15:0] memory_usage;
  } cmd_t;

  typedef struct packed {
    logic [15:0] rate;
    logic        locked;
    logic [1:0]  strategy;
  } attr_t;

  function automatic bias_t clamp_bias(input logic signed [14:0] v, input bias_t lo,
                                       input bias_t hi);
    logic signed [14:0] lo_x;
    logic signed [14:0] hi_x;
    bias_t r;
    lo_x = 15'(lo);
    hi_x = 15'(hi);
    if (v < lo_x) begin
      r = lo;
    end else if (v > hi_x) begin
      r = hi;
    end else begin
      r = v[BiasW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/mbb_front.sv =====
module mbb_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [2:0]                        in_op_i,
  input  logic [mbb_pkg::InDataW-1:0]       in_data_i,
  output logic                              cmd_valid_o,
  output mbb_pkg::cmd_t                     cmd_o,
  input  logic                              cmd_ready_i
);
  import mbb_pkg::*;

  cmd_t       q_mem [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       dec;
  logic       push, pop;

  always_comb begin
    dec.op           = op_e'(in_op_i);
    dec.bulk         = (in_op_i == OP_FORCE_ALL) || (in_op_i == OP_TICK);
    dec.material     = in_data_i[5:0];
    dec.strategy     = in_data_i[7:6];
    dec.bias_value   = in_data_i[20:8];
    dec.flag         = in_data_i[21];
    dec.delta_time   = in_data_i[37:22];
    dec.memory_usage = in_data_i[53:38];
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = 2'(cnt_q + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/mbb_div.sv =====
module mbb_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] num_i,
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [15:0] quo_o
);

  // restoring divide, one quotient bit a cycle; caller ensures num < den
  logic [15:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  logic [15:0] den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [16:0] sh;

  assign done_o = busy_q && (cnt_q == 5'd0);
  assign quo_o  = quo_q;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    sh     = {rem_q, 1'b0};
    if (start_i) begin
      rem_d  = num_i;
      den_d  = den_i;
      quo_d  = '0;
      cnt_d  = 5'd16;
      busy_d = 1'b1;
    end else if (done_o) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      if (sh >= {1'b0, den_q}) begin
        rem_d = 16'(sh - {1'b0, den_q});
        quo_d = {quo_q[14:0], 1'b1};
      end else begin
        rem_d = sh[15:0];
        quo_d = {quo_q[14:0], 1'b0};
      end
      cnt_d = 5'(cnt_q - 5'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 5'd0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

endmodule

// ===== rtl/core/mbb_back.sv =====
module mbb_back #(
  parameter int MATERIALS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_addr_i,
  input  logic [15:0]                  cfg_wdata_i,
  input  logic                         cmd_valid_i,
  output logic                         cmd_ready_o,
  input  mbb_pkg::cmd_t                cmd_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output mbb_pkg::bias_t               out_bias_o,
  output logic                         out_found_o
);
  import mbb_pkg::*;

  localparam int IdxW = (MATERIALS > 1) ? $clog2(MATERIALS) : 1;
  localparam logic [12:0] MatLim  = 13'(MATERIALS);
  localparam logic [IdxW-1:0] LastK = IdxW'(MATERIALS - 1);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_RESP  = 13'b0000000000010,
    S_FORCE = 13'b0000000000100,
    S_FDONE = 13'b0000000001000,
    S_PB    = 13'b0000000010000,
    S_DIV   = 13'b0000000100000,
    S_PP    = 13'b0000001000000,
    S_PM    = 13'b0000010000000,
    S_PR    = 13'b0000100000000,
    S_TRD   = 13'b0001000000000,
    S_TA    = 13'b0010000000000,
    S_TB    = 13'b0100000000000,
    S_TC    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  bias_t       min_q, max_q, off_q, strm_q;
  logic [15:0] rate_q, pstart_q, pfull_q;

  cmd_t          cmd_q, cmd_d;
  logic [IdxW-1:0] k_q, k_d;
  logic [MATERIALS-1:0] valid_q;

  bias_t cur_mem  [MATERIALS];
  bias_t tgt_mem  [MATERIALS];
  attr_t attr_mem [MATERIALS];
  bias_t cur_rd, tgt_rd;
  attr_t attr_rd;

  logic [IdxW-1:0] raddr, waddr;
  logic  cur_we, tgt_we, attr_we;
  bias_t cur_wd, tgt_wd;
  attr_t attr_wd;
  logic  vld_set, vld_clr;

  logic [IdxW-1:0] idx;
  logic            inr, ok0, slot_free;

  // pressure path
  logic [16:0] p_q, p_d;
  logic [32:0] pp_q;
  logic [32:0] pp_full;
  logic signed [46:0] pm_q;
  logic signed [46:0] pm_full;
  logic [46:0] pm_mag;
  logic [14:0] pb_r;
  logic signed [13:0] pb_q, pb_d;
  logic [15:0] p_num, p_den;
  logic        div_start, div_done;
  logic [15:0] div_quo;

  // blend path
  logic signed [13:0] diff_q;
  logic [31:0]        sp_q;
  bias_t              cur_s_q;
  logic signed [31:0] prod_q;
  logic signed [14:0] tsum;
  bias_t              tcl;
  logic [19:0]        sp_sh;
  logic [16:0]        spd;
  logic [31:0]        prod_mag;
  logic [16:0]        step_r;
  logic signed [14:0] step;

  // response
  logic  out_vld_q, out_vld_d;
  bias_t out_bias_q, out_bias_d;
  logic  out_found_q, out_found_d;
  bias_t cur_sel;
  logic  found;

  assign idx         = IdxW'(cmd_q.material);
  assign inr         = {7'd0, cmd_q.material} < MatLim;
  assign ok0         = inr && valid_q[idx];
  assign slot_free   = !out_vld_q || out_ready_i;
  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_bias_o  = out_bias_q;
  assign out_found_o = out_found_q;

  assign p_num = 16'(cmd_q.memory_usage - pstart_q);
  assign p_den = 16'(pfull_q - pstart_q);

  mbb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (p_num),
    .den_i   (p_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // arithmetic between registers
  always_comb begin
    pp_full  = {16'd0, p_q} * {16'd0, p_q};
    pm_full  = $signed({1'b0, pp_q}) * max_q;
    pm_mag   = pm_q[46] ? 47'(-pm_q) : 47'(pm_q);
    pb_r     = 15'((pm_mag + 47'h80000000) >> 32);
    pb_d     = pm_q[46] ? 14'(-$signed({1'b0, pb_r})) : 14'(pb_r);
    tsum     = 15'(tgt_rd) +
               ((attr_rd.strategy == STRAT_PRESSURE) ? 15'(pb_q) : 15'sd0);
    tcl      = clamp_bias(tsum, min_q, max_q);
    sp_sh    = sp_q[31:12];
    spd      = (sp_sh > 20'h10000) ? 17'h10000 : sp_sh[16:0];
    prod_mag = prod_q[31] ? 32'(-prod_q) : 32'(prod_q);
    step_r   = 17'((prod_mag + 32'h8000) >> 16);
    step     = prod_q[31] ? 15'(-$signed({1'b0, step_r})) : 15'(step_r);
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    k_d         = k_q;
    p_d         = p_q;
    raddr       = idx;
    waddr       = idx;
    cur_we      = 1'b0;
    tgt_we      = 1'b0;
    attr_we     = 1'b0;
    cur_wd      = cmd_q.bias_value;
    tgt_wd      = cmd_q.bias_value;
    attr_wd     = '{rate: rate_q, locked: 1'b0, strategy: cmd_q.strategy};
    vld_set     = 1'b0;
    vld_clr     = 1'b0;
    div_start   = 1'b0;
    out_vld_d   = out_ready_i ? 1'b0 : out_vld_q;
    out_bias_d  = out_bias_q;
    out_found_d = out_found_q;
    cur_sel     = cur_rd;
    found       = ok0;

    unique case (state_q)
      S_IDLE: begin
        raddr = IdxW'(cmd_i.material);
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          k_d   = '0;
          if (!cmd_i.bulk) begin
            state_d = S_RESP;
          end else if (cmd_i.op == OP_FORCE_ALL) begin
            state_d = S_FORCE;
          end else begin
            state_d = S_PB;
          end
        end
      end
      S_RESP: begin
        unique case (cmd_q.op)
          OP_REGISTER: begin
            cur_sel = cmd_q.bias_value;
            found   = inr;
            if (inr && slot_free) begin
              cur_we  = 1'b1;
              tgt_we  = 1'b1;
              attr_we = 1'b1;
              vld_set = 1'b1;
            end
          end
          OP_UNREGISTER: begin
            found   = 1'b0;
            vld_clr = ok0 && slot_free;
          end
          OP_SET_TARGET: begin
            tgt_wd = clamp_bias(15'(cmd_q.bias_value), min_q, max_q);
            tgt_we = ok0 && slot_free;
          end
          OP_LOCK: begin
            attr_wd = '{rate: attr_rd.rate, locked: cmd_q.flag, strategy: attr_rd.strategy};
            attr_we = ok0 && slot_free;
          end
          OP_STREAM: begin
            tgt_wd = cmd_q.flag ? strm_q : '0;
            tgt_we = ok0 && slot_free;
          end
          default: begin
          end
        endcase
        if (slot_free) begin
          out_vld_d   = 1'b1;
          out_found_d = found;
          out_bias_d  = found ? clamp_bias(15'(cur_sel) + 15'(off_q), min_q, max_q) : off_q;
          state_d     = S_IDLE;
        end
      end
      S_FORCE: begin
        waddr  = k_q;
        cur_we = valid_q[k_q];
        tgt_we = valid_q[k_q];
        k_d    = IdxW'(k_q + 1'b1);
        if (k_q == LastK) begin
          state_d = S_FDONE;
        end
      end
      S_FDONE: begin
        state_d = S_RESP;
      end
      S_PB: begin
        priority if (cmd_q.memory_usage < pstart_q || pfull_q < pstart_q) begin
          p_d     = '0;
          state_d = S_PP;
        end else if (pfull_q == pstart_q || p_num >= p_den) begin
          p_d     = 17'h10000;
          state_d = S_PP;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          p_d     = {1'b0, div_quo};
          state_d = S_PP;
        end
      end
      S_PP: begin
        state_d = S_PM;
      end
      S_PM: begin
        state_d = S_PR;
      end
      S_PR: begin
        state_d = S_TRD;
      end
      S_TRD: begin
        raddr = k_q;
        if (valid_q[k_q]) begin
          state_d = S_TA;
        end else if (k_q == LastK) begin
          state_d = S_FDONE;
        end else begin
          k_d = IdxW'(k_q + 1'b1);
        end
      end
      S_TA: begin
        raddr = k_q;
        if (!attr_rd.locked) begin
          state_d = S_TB;
        end else if (k_q == LastK) begin
          state_d = S_FDONE;
        end else begin
          k_d     = IdxW'(k_q + 1'b1);
          state_d = S_TRD;
        end
      end
      S_TB: begin
        raddr   = k_q;
        state_d = S_TC;
      end
      S_TC: begin
        raddr  = k_q;
        waddr  = k_q;
        cur_we = 1'b1;
        cur_wd = bias_t'(15'(cur_s_q) + step);
        if (k_q == LastK) begin
          state_d = S_FDONE;
        end else begin
          k_d     = IdxW'(k_q + 1'b1);
          state_d = S_TRD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // table storage, registered reads
  always_ff @(posedge clk_i) begin
    if (cur_we) begin
      cur_mem[waddr] <= cur_wd;
    end
    if (tgt_we) begin
      tgt_mem[waddr] <= tgt_wd;
    end
    if (attr_we) begin
      attr_mem[waddr] <= attr_wd;
    end
    cur_rd  <= cur_mem[raddr];
    tgt_rd  <= tgt_mem[raddr];
    attr_rd <= attr_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    k_q        <= k_d;
    p_q        <= p_d;
    pp_q       <= pp_full;
    pm_q       <= pm_full;
    pb_q       <= (state_q == S_PR) ? pb_d : pb_q;
    diff_q     <= 14'(tcl) - 14'(cur_rd);
    sp_q       <= attr_rd.rate * cmd_q.delta_time;
    cur_s_q    <= (state_q == S_TA) ? cur_rd : cur_s_q;
    prod_q     <= 32'(diff_q) * $signed({15'd0, spd});
    out_bias_q <= out_bias_d;
    out_found_q <= out_found_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      valid_q   <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      if (vld_set) begin
        valid_q[idx] <= 1'b1;
      end
      if (vld_clr) begin
        valid_q[idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= -13'sd512;
      max_q    <= 13'sd512;
      off_q    <= 13'sd0;
      rate_q   <= 16'd6554;
      strm_q   <= 13'sd256;
      pstart_q <= 16'd52429;
      pfull_q  <= 16'd62259;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_MIN_BIAS:       min_q    <= cfg_wdata_i[BiasW-1:0];
        CFG_MAX_BIAS:       max_q    <= cfg_wdata_i[BiasW-1:0];
        CFG_GLOBAL_OFFSET:  off_q    <= cfg_wdata_i[BiasW-1:0];
        CFG_BLEND_RATE:     rate_q   <= cfg_wdata_i;
        CFG_STREAMING_BIAS: strm_q   <= cfg_wdata_i[BiasW-1:0];
        CFG_PRESSURE_START: pstart_q <= cfg_wdata_i;
        CFG_PRESSURE_FULL:  pfull_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/mip_bias_blend_table_unit.sv =====
// Mip-bias blend table over MATERIALS entries. Each request answers with one
// result: the named entry's clamped current bias plus global offset (the
// offset alone when not found) and a found flag. Requests queue two deep
// ahead of a sequencer that handles one at a time over tables with one read
// and one write port and registered reads. Force all writes one entry a
// cycle. Tick first works out the pressure bias (16-step divider and two
// multiplies), then per entry skips it if invalid or locked, else blends
// it, and then answers.
module mip_bias_blend_table_unit #(
  parameter int MATERIALS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [2:0]                      cfg_addr_i,
  input  logic [15:0]                     cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // material, strategy, bias_value, flag, delta_time, memory_usage
  input  logic [mbb_pkg::InDataW-1:0]     s_axis_tdata,
  // op
  input  logic [2:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // effective_bias, found
  output logic [mbb_pkg::OutDataW-1:0]    m_axis_tdata
);
  import mbb_pkg::*;

  logic  cmd_valid, cmd_ready;
  cmd_t  cmd;
  bias_t out_bias;
  logic  out_found;

  mbb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  mbb_back #(
    .MATERIALS (MATERIALS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_bias_o  (out_bias),
    .out_found_o (out_found)
  );

  assign m_axis_tdata = {2'b00, out_found, out_bias};

endmodule

// ===== rtl/core/mbb_checker.sv =====
module mbb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // result reg is cleared by reset
  a_reset_clears_out: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:14] == 2'b00))
    else $error("result padding not zero");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  a_drop_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid) |-> $past(m_axis_tready))
    else $error("result withdrawn before taken");

endmodule

bind mip_bias_blend_table_unit mbb_checker u_mbb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
